[sv/qte_pkg.sv]
// ----------------------------------------------------------------------------
// qte_pkg: shared constants, types and functions for the quaternion to Euler
// angle converter with per-stream unwrapping.
// ----------------------------------------------------------------------------
package qte_pkg;

  // Number of independent attitude streams and the width of a history index.
  localparam int NUM_STREAMS  = 2;
  localparam int STREAM_W     = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

  // CORDIC iteration count and the length of the arctangent table.
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int STEP_W       = 5;

  // Datapath widths.
  localparam int OPD_W = 34;  // atan2 operands, units of 2^-28
  localparam int VEC_W = 36;  // CORDIC vector, with room for gain
  localparam int ANG_W = 28;  // CORDIC angle, units of 2^-24 rad
  localparam int OUT_W = 17;  // output angle, units of 2^-12 rad

  // Angle constants.
  localparam logic signed [ANG_W-1:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [18:0]      PI_Q12      = 19'sd12868;
  localparam logic signed [18:0]      TWO_PI_Q12  = 19'sd25736;
  localparam logic signed [18:0]      ANGLE_LIMIT = 19'sd38603;

  typedef logic signed [OUT_W-1:0] angle_t;

  // Arctangent of 2^-i in units of 2^-24 rad.
  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = 28'sd13176795;
      5'd1:    v = 28'sd7778716;
      5'd2:    v = 28'sd4110060;
      5'd3:    v = 28'sd2086331;
      5'd4:    v = 28'sd1047214;
      5'd5:    v = 28'sd524117;
      5'd6:    v = 28'sd262123;
      5'd7:    v = 28'sd131069;
      5'd8:    v = 28'sd65536;
      5'd9:    v = 28'sd32768;
      5'd10:   v = 28'sd16384;
      5'd11:   v = 28'sd8192;
      5'd12:   v = 28'sd4096;
      5'd13:   v = 28'sd2048;
      5'd14:   v = 28'sd1024;
      5'd15:   v = 28'sd512;
      5'd16:   v = 28'sd256;
      5'd17:   v = 28'sd128;
      5'd18:   v = 28'sd64;
      5'd19:   v = 28'sd32;
      5'd20:   v = 28'sd16;
      5'd21:   v = 28'sd8;
      5'd22:   v = 28'sd4;
      5'd23:   v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Rounds a CORDIC angle to Q.12 and unwraps it against the previous output,
  // saturating to three half-turns either way.
  function automatic angle_t unwrap(input angle_t prev, input logic signed [ANG_W-1:0] raw);
    logic signed [ANG_W:0] rounded;
    logic signed [18:0]    curr;
    logic signed [18:0]    diff;
    rounded = (ANG_W+1)'(raw) + (ANG_W+1)'(2048);
    curr = 19'(rounded >>> 12);
    diff = curr - 19'(prev);
    if (diff > PI_Q12) begin
      curr = curr - TWO_PI_Q12;
    end else if (diff < -PI_Q12) begin
      curr = curr + TWO_PI_Q12;
    end
    if (curr > ANGLE_LIMIT) begin
      curr = ANGLE_LIMIT;
    end
    if (curr < -ANGLE_LIMIT) begin
      curr = -ANGLE_LIMIT;
    end
    return curr[OUT_W-1:0];
  endfunction

endpackage

[sv/qte_cordic.sv]
// ----------------------------------------------------------------------------
// qte_cordic: iterative vectoring CORDIC for atan2
// One rotation step per cycle; the result angle is held until the next start.
// ----------------------------------------------------------------------------
module qte_cordic (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [qte_pkg::OPD_W-1:0]     y_in,
  input  logic signed [qte_pkg::OPD_W-1:0]     x_in,
  output logic                                 done,
  output logic signed [qte_pkg::ANG_W-1:0]     angle
);

  logic                                busy;
  logic [qte_pkg::STEP_W-1:0]          step;
  logic signed [qte_pkg::VEC_W-1:0]    vx;
  logic signed [qte_pkg::VEC_W-1:0]    vy;
  logic signed [qte_pkg::VEC_W-1:0]    xs;
  logic signed [qte_pkg::VEC_W-1:0]    ys;
  logic signed [qte_pkg::VEC_W-1:0]    xe;
  logic signed [qte_pkg::VEC_W-1:0]    ye;

  assign xe = qte_pkg::VEC_W'(x_in);
  assign ye = qte_pkg::VEC_W'(y_in);
  assign xs = vx >>> step;
  assign ys = vy >>> step;

  // Pre-rotation into the right half plane, then one micro-rotation a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= '0;
        if (x_in == '0 && y_in == '0) begin
          angle <= '0;
          done  <= 1'b1;
        end else begin
          busy <= 1'b1;
          if (x_in < 0) begin
            if (y_in >= 0) begin
              vx    <= ye;
              vy    <= -xe;
              angle <= qte_pkg::HALF_PI_Q24;
            end else begin
              vx    <= -ye;
              vy    <= xe;
              angle <= -qte_pkg::HALF_PI_Q24;
            end
          end else begin
            vx    <= xe;
            vy    <= ye;
            angle <= '0;
          end
        end
      end else if (busy) begin
        if (vy >= 0) begin
          vx    <= vx + ys;
          vy    <= vy - xs;
          angle <= angle + qte_pkg::atan_entry(step);
        end else begin
          vx    <= vx - ys;
          vy    <= vy + xs;
          angle <= angle - qte_pkg::atan_entry(step);
        end
        step <= step + 1'b1;
        if (step == qte_pkg::STEP_W'(qte_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/quaternion_to_euler_unwrap.sv]
// ----------------------------------------------------------------------------
// quaternion_to_euler_unwrap: Z-Y-X Euler angles from a unit quaternion
// Roll and yaw by atan2, pitch by asin through a bit-serial square root, each
// angle unwrapped against its stream's previous output.
// ----------------------------------------------------------------------------
//  Channel  Signals                                  Direction
//  in       in_valid/in_ready, stream_number, quat_*  word in
//  out      out_valid/out_ready, *_angle, clamp flag  word out
//
// A word is taken, its nine products are formed on the shared 16x16
// multiplier, the sums are formed, roll and yaw each take a CORDIC pass
// (start, sixteen steps, capture), the sine is squared, the square root
// settles one root bit a cycle, pitch takes a third pass, and the output
// register is loaded. A zero vector into atan2 skips the steps of its pass.
// A new word is taken only when the previous one has moved to the output
// register, so a stalled output holds its word and blocks the input. Reset
// clears the control state and the unwrap histories.
module quaternion_to_euler_unwrap (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [0:0]          stream_number,
  input  logic signed [15:0]  quat_w,
  input  logic signed [15:0]  quat_x,
  input  logic signed [15:0]  quat_y,
  input  logic signed [15:0]  quat_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [16:0]  roll_angle,
  output logic signed [16:0]  pitch_angle,
  output logic signed [16:0]  yaw_angle,
  output logic                pitch_clamped
);

  typedef enum logic [3:0] {
    IDLE, MUL, SUMS, ROLL_GO, ROLL_WAIT, YAW_GO, YAW_WAIT,
    SQUARE, ROOT, PITCH_GO, PITCH_WAIT, FINISH
  } state_t;

  state_t state;

  logic [qte_pkg::STREAM_W-1:0]     sidx;
  logic signed [15:0]               qw, qx, qy, qz;
  logic [3:0]                       k;
  logic signed [31:0]               prod [9];
  logic signed [15:0]               ma, mb;
  logic signed [qte_pkg::OPD_W-1:0] rn, rd, yn, yd;
  logic signed [29:0]               sp;
  logic                             clamped;
  logic [56:0]                      rem;
  logic [57:0]                      root;
  logic [56:0]                      rbit;
  logic [57:0]                      trial;
  qte_pkg::angle_t                  roll_r, yaw_r, pitch_r;
  qte_pkg::angle_t                  prior_roll  [qte_pkg::NUM_STREAMS];
  qte_pkg::angle_t                  prior_pitch [qte_pkg::NUM_STREAMS];
  qte_pkg::angle_t                  prior_yaw   [qte_pkg::NUM_STREAMS];

  logic                             c_start;
  logic signed [qte_pkg::OPD_W-1:0] c_y, c_x;
  logic                             c_done;
  logic signed [qte_pkg::ANG_W-1:0] c_angle;

  logic signed [33:0] s_a, s_b, s_c, s_d, s_e;
  logic [28:0]        sp_mag;

  assign in_ready = (state == IDLE);

  // Operand selection for the shared multiplier.
  always_comb begin
    case (k)
      4'd0:    begin ma = qw; mb = qx; end
      4'd1:    begin ma = qy; mb = qz; end
      4'd2:    begin ma = qx; mb = qx; end
      4'd3:    begin ma = qy; mb = qy; end
      4'd4:    begin ma = qw; mb = qz; end
      4'd5:    begin ma = qx; mb = qy; end
      4'd6:    begin ma = qz; mb = qz; end
      4'd7:    begin ma = qw; mb = qy; end
      4'd8:    begin ma = qz; mb = qx; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // Sums of products, each doubled.
  always_comb begin
    s_a = (34'(prod[0]) + 34'(prod[1])) <<< 1;
    s_b = (34'(prod[2]) + 34'(prod[3])) <<< 1;
    s_c = (34'(prod[4]) + 34'(prod[5])) <<< 1;
    s_d = (34'(prod[3]) + 34'(prod[6])) <<< 1;
    s_e = (34'(prod[7]) - 34'(prod[8])) <<< 1;
  end

  assign sp_mag = sp[29] ? 29'(-sp) : 29'(sp);
  assign trial  = root + {1'b0, rbit};

  // Operands and start for the CORDIC unit.
  always_comb begin
    c_start = 1'b0;
    c_y     = rn;
    c_x     = rd;
    case (state)
      ROLL_GO: begin
        c_start = 1'b1;
      end
      YAW_GO: begin
        c_start = 1'b1;
        c_y     = yn;
        c_x     = yd;
      end
      PITCH_WAIT, PITCH_GO: begin
        c_start = (state == PITCH_GO);
        c_y     = qte_pkg::OPD_W'(sp);
        c_x     = qte_pkg::OPD_W'(root[28:0]);
      end
      default: begin
        c_start = 1'b0;
      end
    endcase
  end

  qte_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (c_start),
    .y_in  (c_y),
    .x_in  (c_x),
    .done  (c_done),
    .angle (c_angle)
  );

  // Sequencer, histories and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      k         <= '0;
      for (int i = 0; i < qte_pkg::NUM_STREAMS; i++) begin
        prior_roll[i]  <= '0;
        prior_pitch[i] <= '0;
        prior_yaw[i]   <= '0;
      end
    end else begin
      if (out_valid && out_ready && state != FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            sidx  <= qte_pkg::STREAM_W'(stream_number % qte_pkg::NUM_STREAMS);
            qw    <= quat_w;
            qx    <= quat_x;
            qy    <= quat_y;
            qz    <= quat_z;
            k     <= '0;
            state <= MUL;
          end
        end
        MUL: begin
          prod[k] <= ma * mb;
          k       <= k + 1'b1;
          if (k == 4'd8) begin
            state <= SUMS;
          end
        end
        SUMS: begin
          rn <= s_a;
          rd <= 34'sd268435456 - s_b;
          yn <= s_c;
          yd <= 34'sd268435456 - s_d;
          if (s_e > 34'sd268435456) begin
            sp      <= 30'sd268435456;
            clamped <= 1'b1;
          end else if (s_e < -34'sd268435456) begin
            sp      <= -30'sd268435456;
            clamped <= 1'b1;
          end else begin
            sp      <= 30'(s_e);
            clamped <= 1'b0;
          end
          state <= ROLL_GO;
        end
        ROLL_GO: begin
          state <= ROLL_WAIT;
        end
        ROLL_WAIT: begin
          if (c_done) begin
            roll_r <= qte_pkg::unwrap(prior_roll[sidx], c_angle);
            state  <= YAW_GO;
          end
        end
        YAW_GO: begin
          state <= YAW_WAIT;
        end
        YAW_WAIT: begin
          if (c_done) begin
            yaw_r <= qte_pkg::unwrap(prior_yaw[sidx], c_angle);
            state <= SQUARE;
          end
        end
        SQUARE: begin
          // Radicand is one minus the squared sine, in units of 2^-56.
          rem   <= (57'd1 << 56) - 57'(sp_mag * sp_mag);
          root  <= '0;
          rbit  <= 57'd1 << 56;
          state <= ROOT;
        end
        ROOT: begin
          // One root bit a cycle, restoring form.
          if ({1'b0, rem} >= trial) begin
            rem  <= 57'({1'b0, rem} - trial);
            root <= (root >> 1) + {1'b0, rbit};
          end else begin
            root <= root >> 1;
          end
          rbit <= rbit >> 2;
          if (rbit[0]) begin
            state <= PITCH_GO;
          end
        end
        PITCH_GO: begin
          state <= PITCH_WAIT;
        end
        PITCH_WAIT: begin
          if (c_done) begin
            pitch_r <= qte_pkg::unwrap(prior_pitch[sidx], c_angle);
            state   <= FINISH;
          end
        end
        FINISH: begin
          if (!out_valid || out_ready) begin
            roll_angle        <= roll_r;
            pitch_angle       <= pitch_r;
            yaw_angle         <= yaw_r;
            pitch_clamped     <= clamped;
            out_valid         <= 1'b1;
            prior_roll[sidx]  <= roll_r;
            prior_pitch[sidx] <= pitch_r;
            prior_yaw[sidx]   <= yaw_r;
            state             <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
